### design/assert_macros.svh
// Assertion macros shared by the sample validator RTL.
// Each macro expects signals named clk and rst_n in the including scope.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// The property must hold at every clock edge outside reset.
`define TSV_ASSERT(name, prop, msg) \
    name: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error(msg);

// The expression must never be true at a clock edge outside reset.
`define TSV_ASSERT_NEVER(name, expr, msg) \
    name: assert property (@(posedge clk) disable iff (!rst_n) !(expr)) \
        else $error(msg);

`endif

### design/tsv_pkg.sv
`timescale 1ns / 1ps
// Shared types and constants of the temperature sample validator.
// Used by every module of the block; depends on nothing.
package tsv_pkg;

    // Sample and register widths.
    localparam int SAMPLE_W   = 12;
    localparam int SPREAD_W   = 11;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 12;

    // Samples that make up one attempt, and the width of the index into them.
    localparam int SAMPLES_PER_ATTEMPT = 3;
    localparam int IDX_W               = 2;

    typedef logic signed [SAMPLE_W-1:0] sample_t;
    typedef logic [1:0]                 reason_t;
    typedef logic [CFG_IDX_W-1:0]       cfg_idx_t;

    // Reading the sensor returns for a lost connection (-127 degrees).
    localparam sample_t DISCONNECT_CODE = -12'sd2032;

    // Failure reasons.
    localparam reason_t REASON_NONE         = 2'd0;
    localparam reason_t REASON_DISCONNECT   = 2'd1;
    localparam reason_t REASON_RANGE        = 2'd2;
    localparam reason_t REASON_INCONSISTENT = 2'd3;

    // Configuration register indexes.
    localparam cfg_idx_t CFG_MIN_VALID  = 2'd0;
    localparam cfg_idx_t CFG_MAX_VALID  = 2'd1;
    localparam cfg_idx_t CFG_MAX_SPREAD = 2'd2;

    // Reset values of the configuration registers.
    localparam sample_t              MIN_VALID_RST  = -12'sd880;
    localparam sample_t              MAX_VALID_RST  = 12'sd2000;
    localparam logic [SPREAD_W-1:0]  MAX_SPREAD_RST = 11'd16;

    // Divide by three: floor(n * RECIP_3 / 2^RECIP_SHIFT) equals floor(n / 3)
    // for every n below 2^14. The offset keeps the dividend positive.
    localparam int                RECIP_SHIFT = 16;
    localparam logic [14:0]       RECIP_3     = 15'd21846;
    localparam logic signed [14:0] MEAN_BIAS  = 15'sd6148;
    localparam logic [12:0]       MEAN_UNBIAS = 13'd2049;

    // Classification of one sample against the marker and the range.
    typedef struct packed {
        logic disconnect;
        logic out_of_range;
    } tsv_class_t;

    // Outcome of the spread check over a full attempt.
    typedef struct packed {
        logic    good;
        sample_t mean;
    } tsv_check_t;

endpackage

### design/tsv_classify.sv
`timescale 1ns / 1ps
// Sample classifier: flags the disconnect marker and out-of-range readings.
// Depends on tsv_pkg.
module tsv_classify
    import tsv_pkg::*;
(
    input  sample_t    sample,
    input  sample_t    min_valid,
    input  sample_t    max_valid,
    output tsv_class_t cls
);

    // Raw flags; the sequencer gives the marker priority over the range.
    always_comb
    begin
        cls.disconnect   = (sample == DISCONNECT_CODE);
        cls.out_of_range = (sample < min_valid) || (sample > max_valid);
    end

endmodule

### design/tsv_consistency.sv
`timescale 1ns / 1ps
// Spread check and rounded mean over the two stored samples and the current one.
// Depends on tsv_pkg.
module tsv_consistency
    import tsv_pkg::*;
(
    input  sample_t             store0,
    input  sample_t             store1,
    input  sample_t             sample,
    input  logic [SPREAD_W-1:0] max_spread,
    output tsv_check_t          chk
);

    logic signed [13:0] s0_x;
    logic signed [13:0] s1_x;
    logic signed [13:0] s2_x;
    logic signed [13:0] sum;
    logic signed [13:0] t0;
    logic signed [13:0] t1;
    logic signed [13:0] t2;
    logic signed [14:0] d0;
    logic signed [14:0] d1;
    logic signed [14:0] d2;
    logic [13:0]        a0;
    logic [13:0]        a1;
    logic [13:0]        a2;
    logic [12:0]        limit;
    logic               good_w;
    logic signed [14:0] biased;
    logic [13:0]        dividend;
    logic [28:0]        product;
    logic [12:0]        quotient;
    logic [12:0]        mean_w;

    // Sum of the three samples and three times each sample.
    always_comb
    begin
        s0_x = {{2{store0[SAMPLE_W-1]}}, store0};
        s1_x = {{2{store1[SAMPLE_W-1]}}, store1};
        s2_x = {{2{sample[SAMPLE_W-1]}}, sample};
        sum  = s0_x + s1_x + s2_x;
        t0   = (s0_x <<< 1) + s0_x;
        t1   = (s1_x <<< 1) + s1_x;
        t2   = (s2_x <<< 1) + s2_x;
    end

    // Distance of each sample from the mean, scaled by three.
    always_comb
    begin
        d0 = {t0[13], t0} - {sum[13], sum};
        d1 = {t1[13], t1} - {sum[13], sum};
        d2 = {t2[13], t2} - {sum[13], sum};
        a0 = d0[14] ? 14'(-d0) : d0[13:0];
        a1 = d1[14] ? 14'(-d1) : d1[13:0];
        a2 = d2[14] ? 14'(-d2) : d2[13:0];
        limit = 13'({max_spread, 1'b0}) + 13'(max_spread);
        good_w = (a0 <= {1'b0, limit}) && (a1 <= {1'b0, limit})
                 && (a2 <= {1'b0, limit});
    end

    // Rounded mean floor((sum + 1) / 3) through a reciprocal multiply.
    always_comb
    begin
        biased   = {sum[13], sum} + MEAN_BIAS;
        dividend = biased[13:0];
        product  = 29'(dividend) * 29'(RECIP_3);
        quotient = product[28:RECIP_SHIFT];
        mean_w   = quotient - MEAN_UNBIAS;
    end

    // Verdict: the good flag above the mean.
    assign chk = {good_w, mean_w[SAMPLE_W-1:0]};

endmodule

### design/tsv_sequencer.sv
`timescale 1ns / 1ps
// Attempt sequencer: sample store, attempt bookkeeping and the result register.
// Depends on tsv_pkg and assert_macros.svh.
`include "assert_macros.svh"
module tsv_sequencer
    import tsv_pkg::*;
#(
    parameter int MAX_ATTEMPTS = 2
)
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       item_valid,
    input  sample_t    item_sample,
    input  tsv_class_t item_class,
    input  tsv_check_t item_check,
    input  logic       out_ready,
    output logic       consume,
    output sample_t    store0,
    output sample_t    store1,
    output logic       out_valid,
    output logic       ok,
    output sample_t    temperature,
    output logic [1:0] attempts_taken,
    output reason_t    fail_reason
);

    localparam int ATT_W = (MAX_ATTEMPTS > 1) ? $clog2(MAX_ATTEMPTS) : 1;

    logic [IDX_W-1:0] idx_reg;
    logic [IDX_W-1:0] idx_next;
    logic [ATT_W-1:0] att_reg;
    logic [ATT_W-1:0] att_next;
    reason_t          prev_reg;
    reason_t          prev_next;
    sample_t          store0_reg;
    sample_t          store1_reg;
    logic             out_valid_reg;
    logic             ok_reg;
    logic             ok_next;
    sample_t          temperature_reg;
    sample_t          temperature_next;
    logic [1:0]       attempts_reg;
    logic [1:0]       attempts_next;
    reason_t          reason_reg;
    reason_t          reason_next;

    logic             third;
    logic             success;
    logic             failed;
    logic             last_attempt;
    logic             produce;
    logic             load;
    reason_t          reason;
    logic [ATT_W:0]   att_plus;

    // Decide what the current sample does to the attempt.
    always_comb
    begin
        third        = (idx_reg == IDX_W'(SAMPLES_PER_ATTEMPT - 1));
        failed       = item_class.disconnect || item_class.out_of_range
                       || (third && !item_check.good);
        success      = third && item_check.good && !item_class.disconnect
                       && !item_class.out_of_range;
        last_attempt = (att_reg == ATT_W'(MAX_ATTEMPTS - 1));
        produce      = success || (failed && last_attempt);
        consume      = item_valid && (!produce || !out_valid_reg || out_ready);
        load         = consume && produce;
        att_plus     = {1'b0, att_reg} + (ATT_W+1)'(1);
        if (item_class.disconnect)
        begin
            reason = REASON_DISCONNECT;
        end
        else if (item_class.out_of_range)
        begin
            reason = REASON_RANGE;
        end
        else
        begin
            reason = REASON_INCONSISTENT;
        end
    end

    // Next attempt state and result payload.
    always_comb
    begin
        idx_next         = idx_reg;
        att_next         = att_reg;
        prev_next        = prev_reg;
        ok_next          = success;
        temperature_next = success ? item_check.mean : '0;
        attempts_next    = att_plus[1:0];
        reason_next      = success ? prev_reg : reason;
        if (consume)
        begin
            if (produce)
            begin
                idx_next  = '0;
                att_next  = '0;
                prev_next = REASON_NONE;
            end
            else if (failed)
            begin
                idx_next  = '0;
                att_next  = att_plus[ATT_W-1:0];
                prev_next = reason;
            end
            else
            begin
                idx_next = idx_reg + IDX_W'(1);
            end
        end
    end

    // Control state and result valid.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            idx_reg       <= '0;
            att_reg       <= '0;
            prev_reg      <= REASON_NONE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            idx_reg  <= idx_next;
            att_reg  <= att_next;
            prev_reg <= prev_next;
            if (load)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // Sample store and result payload; written before they are read.
    always_ff @(posedge clk)
    begin
        if (consume && !failed && !third)
        begin
            if (idx_reg == IDX_W'(0))
            begin
                store0_reg <= item_sample;
            end
            else
            begin
                store1_reg <= item_sample;
            end
        end
        if (load)
        begin
            ok_reg          <= ok_next;
            temperature_reg <= temperature_next;
            attempts_reg    <= attempts_next;
            reason_reg      <= reason_next;
        end
    end

    assign store0         = store0_reg;
    assign store1         = store1_reg;
    assign out_valid      = out_valid_reg;
    assign ok             = ok_reg;
    assign temperature    = temperature_reg;
    assign attempts_taken = attempts_reg;
    assign fail_reason    = reason_reg;

    // The sample index wraps after the third sample of an attempt.
    `TSV_ASSERT_NEVER(a_idx_bound, idx_reg == IDX_W'(SAMPLES_PER_ATTEMPT), "sample index overran")
    // Every emitted result starts a fresh sequence.
    `TSV_ASSERT(a_seq_restart, load |=> (idx_reg == '0) && (att_reg == '0), "sequence not restarted")
    // A first-try success carries no earlier reason.
    `TSV_ASSERT(a_first_ok, out_valid_reg && ok_reg && (attempts_reg == 2'd1) |-> reason_reg == REASON_NONE, "stale reason on first success")
    // A failure reports zero temperature and a real reason.
    `TSV_ASSERT(a_fail_payload, out_valid_reg && !ok_reg |-> (temperature_reg == '0) && (reason_reg != REASON_NONE), "bad failure payload")

endmodule

### design/temp_sample_validator_top.sv
`timescale 1ns / 1ps
// Top level of the temperature sample validator.
// Depends on tsv_pkg, tsv_classify, tsv_consistency and tsv_sequencer.
//
// Takes one signed 1/16-degree sample per cycle and groups good samples into
// attempts of three; the disconnect marker or a reading outside the
// configured range ends an attempt early, and a full attempt passes when all
// three samples lie within max_spread of their mean. A result (success with
// the rounded mean, or failure after MAX_ATTEMPTS failed attempts) reaches the
// output by way of the input register and the result register: the sample
// that completes it is captured in the input register at its transfer, and
// the check feeds the result register when the sequencer takes that sample.
// Throughput is one sample per cycle; the input side stalls only when a
// sample that completes a result meets a result register still waiting for
// its transfer. Configuration writes take effect on the next cycle.
module temp_sample_validator_top
    import tsv_pkg::*;
#(
    parameter int MAX_ATTEMPTS = 2
)
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  in_valid,
    output logic                  in_ready,
    input  sample_t               sample,
    output logic                  out_valid,
    input  logic                  out_ready,
    output logic                  ok,
    output sample_t               temperature,
    output logic [1:0]            attempts_taken,
    output reason_t               fail_reason,
    input  logic                  cfg_we,
    input  cfg_idx_t              cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data
);

    logic                in_valid_reg;
    sample_t             in_sample_reg;
    sample_t             min_valid_reg;
    sample_t             max_valid_reg;
    logic [SPREAD_W-1:0] max_spread_reg;
    logic                consume;
    sample_t             store0;
    sample_t             store1;
    tsv_class_t          cls;
    tsv_check_t          chk;

    // Input register; it frees whenever the sequencer takes its sample.
    assign in_ready = !in_valid_reg || consume;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
        end
        else if (in_ready)
        begin
            in_valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_valid && in_ready)
        begin
            in_sample_reg <= sample;
        end
    end

    // Configuration registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            min_valid_reg  <= MIN_VALID_RST;
            max_valid_reg  <= MAX_VALID_RST;
            max_spread_reg <= MAX_SPREAD_RST;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                CFG_MIN_VALID:  min_valid_reg  <= cfg_data;
                CFG_MAX_VALID:  max_valid_reg  <= cfg_data;
                CFG_MAX_SPREAD: max_spread_reg <= cfg_data[SPREAD_W-1:0];
                default:        ;
            endcase
        end
    end

    tsv_classify u_classify (
        .sample    (in_sample_reg),
        .min_valid (min_valid_reg),
        .max_valid (max_valid_reg),
        .cls       (cls)
    );

    tsv_consistency u_consistency (
        .store0     (store0),
        .store1     (store1),
        .sample     (in_sample_reg),
        .max_spread (max_spread_reg),
        .chk        (chk)
    );

    tsv_sequencer #(
        .MAX_ATTEMPTS (MAX_ATTEMPTS)
    ) u_sequencer (
        .clk            (clk),
        .rst_n          (rst_n),
        .item_valid     (in_valid_reg),
        .item_sample    (in_sample_reg),
        .item_class     (cls),
        .item_check     (chk),
        .out_ready      (out_ready),
        .consume        (consume),
        .store0         (store0),
        .store1         (store1),
        .out_valid      (out_valid),
        .ok             (ok),
        .temperature    (temperature),
        .attempts_taken (attempts_taken),
        .fail_reason    (fail_reason)
    );

endmodule

### test/tb_temp_sample_validator_top.sv
`timescale 1ns / 1ps
// Testbench of temp_sample_validator_top: sends samples over the valid/ready input,
// predicts every verdict and checks each result transfer field by field.
// Depends on tsv_pkg and on the design sources of temp_sample_validator_top.
module tb_temp_sample_validator_top;
    import tsv_pkg::*;

    localparam int ATTEMPT_LIMIT  = 2;
    localparam int CYCLE_LIMIT    = 200000;
    localparam int SETTLE_CYCLES  = 4;
    localparam int TAIL_CYCLES    = 8;
    localparam int RANDOM_BATCH   = 290;
    localparam int REPORT_LIMIT   = 40;

    // One verdict as the block reports it.
    typedef struct packed {
        logic        ok;
        sample_t     temperature;
        logic [1:0]  attempts;
        reason_t     reason;
    } verdict_t;

    logic                  clk;
    logic                  rst_n;
    logic                  in_valid;
    logic                  in_ready;
    sample_t               sample;
    logic                  out_valid;
    logic                  out_ready = 1'b0;
    logic                  ok;
    sample_t               temperature;
    logic [1:0]            attempts_taken;
    reason_t               fail_reason;
    logic                  cfg_we;
    cfg_idx_t              cfg_index;
    logic [CFG_DATA_W-1:0] cfg_data;

    verdict_t pending_verdicts[$];
    int       mismatch_count = 0;
    int       cycle_count    = 0;
    int       send_idle_pct;
    int       recv_idle_pct;

    // Predictor copy of the limits and of the attempt state.
    int      lim_min;
    int      lim_max;
    int      lim_spread;
    int      held[SAMPLES_PER_ATTEMPT];
    int      held_count;
    int      failed_attempts;
    reason_t last_reason;

    temp_sample_validator_top #(
        .MAX_ATTEMPTS (ATTEMPT_LIMIT)
    ) dut (
        .clk            (clk),
        .rst_n          (rst_n),
        .in_valid       (in_valid),
        .in_ready       (in_ready),
        .sample         (sample),
        .out_valid      (out_valid),
        .out_ready      (out_ready),
        .ok             (ok),
        .temperature    (temperature),
        .attempts_taken (attempts_taken),
        .fail_reason    (fail_reason),
        .cfg_we         (cfg_we),
        .cfg_index      (cfg_index),
        .cfg_data       (cfg_data)
    );

    // Clock with a 20 ns period.
    always
    begin
        clk = 1'b0;
        #10;
        clk = 1'b1;
        #10;
    end

    // Free-running cycle count for the watchdog.
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
    end

    // The run is declared hung once the cycle count reaches the limit.
    initial
    begin
        wait (cycle_count >= CYCLE_LIMIT);
        $display("temp_sample_validator_top verification failed");
        $finish;
    end

    // Works out the verdict caused by one accepted sample; returns 1 when there is one.
    function automatic bit judge_reading(input sample_t s, output verdict_t v);
        int      value;
        int      total;
        int      dev;
        int      mean;
        bit      consistent;
        reason_t reason;
        value = s;
        v = '0;
        if (s == DISCONNECT_CODE)
        begin
            reason = REASON_DISCONNECT;
        end
        else if (value < lim_min || value > lim_max)
        begin
            reason = REASON_RANGE;
        end
        else
        begin
            held[held_count] = value;
            held_count++;
            if (held_count < SAMPLES_PER_ATTEMPT)
            begin
                return 1'b0;
            end
            total = held[0] + held[1] + held[2];
            consistent = 1'b1;
            foreach (held[i])
            begin
                dev = 3 * held[i] - total;
                if (dev < 0)
                begin
                    dev = -dev;
                end
                if (dev > 3 * lim_spread)
                begin
                    consistent = 1'b0;
                end
            end
            if (consistent)
            begin
                // Round to nearest: floor((total + 1) / 3), with division truncating
                // toward zero corrected for negative dividends.
                mean = (total + 1) / 3;
                if ((total + 1) % 3 != 0 && total + 1 < 0)
                begin
                    mean--;
                end
                v.ok          = 1'b1;
                v.temperature = sample_t'(mean);
                v.attempts    = 2'(failed_attempts + 1);
                v.reason      = last_reason;
                held_count      = 0;
                failed_attempts = 0;
                last_reason     = REASON_NONE;
                return 1'b1;
            end
            reason = REASON_INCONSISTENT;
        end
        // The attempt has failed.
        held_count  = 0;
        last_reason = reason;
        if (failed_attempts + 1 >= ATTEMPT_LIMIT)
        begin
            v.attempts      = 2'(failed_attempts + 1);
            v.reason        = reason;
            failed_attempts = 0;
            last_reason     = REASON_NONE;
            return 1'b1;
        end
        failed_attempts++;
        return 1'b0;
    endfunction

    function automatic void note_mismatch(input string field, input int want, input int got);
        mismatch_count++;
        if (mismatch_count <= REPORT_LIMIT)
        begin
            $display("%0t: %s expected %0d actual %0d", $time, field, want, got);
        end
    endfunction

    // Result checker; it also drives out_ready with random stalls.
    always @(posedge clk)
    begin : result_check
        verdict_t want;
        if (rst_n && out_valid && out_ready)
        begin
            if (pending_verdicts.size() == 0)
            begin
                mismatch_count++;
                if (mismatch_count <= REPORT_LIMIT)
                begin
                    $display("%0t: result expected none actual ok %0b temperature %0d attempts %0d reason %0d",
                             $time, ok, temperature, attempts_taken, fail_reason);
                end
            end
            else
            begin
                want = pending_verdicts.pop_front();
                if (ok !== want.ok)
                begin
                    note_mismatch("ok", want.ok, ok);
                end
                if (temperature !== want.temperature)
                begin
                    note_mismatch("temperature", want.temperature, temperature);
                end
                if (attempts_taken !== want.attempts)
                begin
                    note_mismatch("attempts_taken", want.attempts, attempts_taken);
                end
                if (fail_reason !== want.reason)
                begin
                    note_mismatch("fail_reason", want.reason, fail_reason);
                end
            end
        end
        out_ready <= ($urandom_range(99) >= recv_idle_pct);
    end

    // Sends one sample, with random idle cycles before it, and predicts its verdict.
    task automatic send_sample(input sample_t s);
        verdict_t v;
        while ($urandom_range(99) < send_idle_pct)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid <= 1'b1;
        sample   <= s;
        do
            @(posedge clk);
        while (!in_ready);
        if (judge_reading(s, v))
        begin
            pending_verdicts.push_back(v);
        end
    endtask

    // Holds the input off until every predicted verdict has been checked.
    task automatic hold_until_drained();
        in_valid <= 1'b0;
        do
            @(posedge clk);
        while (pending_verdicts.size() != 0);
    endtask

    // Lets samples that cause no result leave the pipeline as well.
    task automatic settle();
        hold_until_drained();
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic write_limits(input int lo, input int hi, input logic [11:0] spread_word);
        cfg_we    <= 1'b1;
        cfg_index <= CFG_MIN_VALID;
        cfg_data  <= 12'(lo);
        @(posedge clk);
        cfg_index <= CFG_MAX_VALID;
        cfg_data  <= 12'(hi);
        @(posedge clk);
        cfg_index <= CFG_MAX_SPREAD;
        cfg_data  <= spread_word;
        @(posedge clk);
        cfg_we     <= 1'b0;
        lim_min    = lo;
        lim_max    = hi;
        lim_spread = spread_word[SPREAD_W-1:0];
    endtask

    // Reset limits: rounding both ways, abort reasons, and a second-attempt success.
    task automatic test_reset_limits();
        send_sample(12'sd400);
        send_sample(12'sd401);
        send_sample(12'sd401);
        send_sample(DISCONNECT_CODE);
        send_sample(12'sd2047);
        send_sample(12'sd0);
        send_sample(12'sd50);
        send_sample(12'sd0);
        send_sample(-12'sd5);
        send_sample(-12'sd5);
        send_sample(-12'sd6);
    endtask

    // Full range and widest spread: both sample extremes, and the marker
    // still counts as a disconnect while inside the range.
    task automatic test_full_scale();
        settle();
        write_limits(-2048, 2047, 12'd2047);
        send_sample(-12'sd2048);
        send_sample(-12'sd2048);
        send_sample(-12'sd2048);
        send_sample(DISCONNECT_CODE);
        send_sample(12'sd2047);
        send_sample(12'sd2047);
        send_sample(12'sd2047);
    endtask

    // Zero spread fails any unequal attempt; an empty range rejects every sample.
    task automatic test_tight_and_empty_limits();
        settle();
        write_limits(-2048, 2047, 12'd0);
        send_sample(12'sd7);
        send_sample(12'sd7);
        send_sample(12'sd8);
        settle();
        write_limits(2047, -2048, 12'd16);
        send_sample(12'sd0);
    endtask

    // Mostly attempts of samples around a random center, mixed with markers,
    // range violations and noise.
    task automatic random_traffic(input int count);
        int center;
        int v;
        int reach;
        int pick;
        center = 0;
        for (int n = 0; n < count; n++)
        begin
            if (n % SAMPLES_PER_ATTEMPT == 0)
            begin
                if (lim_min <= lim_max)
                begin
                    center = lim_min + int'($urandom_range(lim_max - lim_min));
                end
                else
                begin
                    center = int'($urandom_range(4095)) - 2048;
                end
            end
            pick = $urandom_range(99);
            if (pick < 4)
            begin
                v = DISCONNECT_CODE;
            end
            else if (pick < 10)
            begin
                v = int'($urandom_range(4095)) - 2048;
            end
            else if (pick < 15)
            begin
                if ($urandom_range(1) == 0)
                begin
                    v = lim_min - 1 - int'($urandom_range(3));
                end
                else
                begin
                    v = lim_max + 1 + int'($urandom_range(3));
                end
            end
            else
            begin
                reach = (pick < 75) ? lim_spread / 2 : lim_spread + 2;
                v = center - reach + int'($urandom_range(2 * reach));
                if (lim_min <= lim_max)
                begin
                    if (v < lim_min)
                    begin
                        v = lim_min;
                    end
                    if (v > lim_max)
                    begin
                        v = lim_max;
                    end
                end
            end
            if (v < -2048)
            begin
                v = -2048;
            end
            if (v > 2047)
            begin
                v = 2047;
            end
            send_sample(sample_t'(v));
            if ($urandom_range(149) == 0)
            begin
                hold_until_drained();
            end
        end
    endtask

    task automatic test_random_phase(input int send_pct, input int recv_pct, input int lo,
                                     input int hi, input logic [11:0] spread_word);
        int          rlo;
        int          rhi;
        int          swap;
        logic [11:0] rspread;
        send_idle_pct = send_pct;
        recv_idle_pct = recv_pct;
        settle();
        write_limits(lo, hi, spread_word);
        random_traffic(RANDOM_BATCH);
        // Then random limits, now and then an empty range.
        rlo = int'($urandom_range(4095)) - 2048;
        rhi = int'($urandom_range(4095)) - 2048;
        if (rlo > rhi && $urandom_range(3) != 0)
        begin
            swap = rlo;
            rlo  = rhi;
            rhi  = swap;
        end
        if ($urandom_range(3) == 0)
        begin
            rspread = 12'($urandom);
        end
        else
        begin
            rspread     = 12'($urandom_range(80));
            rspread[11] = 1'($urandom_range(1));
        end
        settle();
        write_limits(rlo, rhi, rspread);
        random_traffic(RANDOM_BATCH);
    endtask

    initial
    begin
        in_valid  <= 1'b0;
        sample    <= '0;
        cfg_we    <= 1'b0;
        cfg_index <= CFG_MIN_VALID;
        cfg_data  <= '0;
        rst_n     <= 1'b0;
        lim_min         = MIN_VALID_RST;
        lim_max         = MAX_VALID_RST;
        lim_spread      = MAX_SPREAD_RST;
        held_count      = 0;
        failed_attempts = 0;
        last_reason     = REASON_NONE;
        send_idle_pct   = 37;
        recv_idle_pct   = 66;
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;

        test_reset_limits();
        test_full_scale();
        test_tight_and_empty_limits();
        test_random_phase(37, 66, -880, 2000, 12'd16);
        test_random_phase(66, 37, -2048, 2047, 12'd0);
        test_random_phase(0, 0, -2048, 2047, 12'd2047);

        hold_until_drained();
        repeat (TAIL_CYCLES) @(posedge clk);
        if (mismatch_count == 0 && pending_verdicts.size() == 0)
        begin
            $display("temp_sample_validator_top verification clean");
        end
        else
        begin
            $display("temp_sample_validator_top verification failed");
        end
        $finish;
    end

endmodule
